/* hdl/bdq_pkg.sv */
// ============================================================================
// bdq_pkg
// Shared types, constants and helpers for the bounded deque engine.
// ============================================================================
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = OCC_W + 1;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] slot;
        logic              wr;
        logic              rd;
        status_t           status;
        logic [OCC_W-1:0]  occ_after;
    } op_t;

    // Folds a position below twice the depth back into the slot range.
    function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] pos);
        logic [SUM_W-1:0] folded;
        begin
            folded = pos;
            if (pos >= SUM_W'(DEPTH))
            begin
                folded = pos - SUM_W'(DEPTH);
            end
            wrap_slot = folded[ADDR_W-1:0];
        end
    endfunction

endpackage

/* hdl/bdq_ram.sv */
// ============================================================================
// bdq_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bdq_ptr.sv */
// ============================================================================
// bdq_ptr
// Front pointer and occupancy count; decodes each operation into a slot
// address, memory commands, a status code and the occupancy after the step.
// ============================================================================
module bdq_ptr (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [1:0]               mode,
    output bdq_pkg::op_t             op
);

    logic [bdq_pkg::ADDR_W-1:0] front_reg;
    logic [bdq_pkg::ADDR_W-1:0] front_next;
    logic [bdq_pkg::OCC_W-1:0]  occ_reg;
    logic [bdq_pkg::OCC_W-1:0]  occ_next;
    logic [bdq_pkg::SUM_W-1:0]  rear_pos;
    logic [bdq_pkg::ADDR_W-1:0] front_dec;
    logic [bdq_pkg::ADDR_W-1:0] front_inc;
    logic                       is_full;
    logic                       is_empty;

    assign is_full  = (occ_reg == bdq_pkg::OCC_W'(bdq_pkg::DEPTH));
    assign is_empty = (occ_reg == '0);
    assign rear_pos = bdq_pkg::SUM_W'(front_reg) + bdq_pkg::SUM_W'(occ_reg);

    assign front_dec = (front_reg == '0) ?
                       bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1)) ?
                       '0 : front_reg + 1'b1;

    always_comb
    begin
        op.slot      = front_reg;
        op.wr        = 1'b0;
        op.rd        = 1'b0;
        op.status    = bdq_pkg::STATUS_DONE;
        op.occ_after = occ_reg;
        front_next   = front_reg;
        case (bdq_pkg::mode_t'(mode))
            bdq_pkg::MODE_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    op.status = bdq_pkg::STATUS_FULL;
                end
                else
                begin
                    op.slot      = front_dec;
                    op.wr        = 1'b1;
                    op.occ_after = occ_reg + 1'b1;
                    front_next   = front_dec;
                end
            end
            bdq_pkg::MODE_PUSH_REAR:
            begin
                if (is_full)
                begin
                    op.status = bdq_pkg::STATUS_FULL;
                end
                else
                begin
                    op.slot      = bdq_pkg::wrap_slot(rear_pos);
                    op.wr        = 1'b1;
                    op.occ_after = occ_reg + 1'b1;
                end
            end
            bdq_pkg::MODE_POP_FRONT:
            begin
                if (is_empty)
                begin
                    op.status = bdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    op.slot      = front_reg;
                    op.rd        = 1'b1;
                    op.occ_after = occ_reg - 1'b1;
                    front_next   = front_inc;
                end
            end
            bdq_pkg::MODE_POP_REAR:
            begin
                if (is_empty)
                begin
                    op.status = bdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    op.slot      = bdq_pkg::wrap_slot(rear_pos - 1'b1);
                    op.rd        = 1'b1;
                    op.occ_after = occ_reg - 1'b1;
                end
            end
            default:
            begin
                op.status = bdq_pkg::STATUS_DONE;
            end
        endcase
    end

    assign occ_next = step ? op.occ_after : occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (step)
            begin
                front_reg <= front_next;
            end
        end
    end

endmodule

/* hdl/bounded_deque_engine.sv */
// ============================================================================
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit words held in a circular store.
// ============================================================================
// Each transfer on the item channel (item_valid high, item_stall low) carries
// a mode and a value: push front, push rear, pop front or pop rear. Every
// item produces exactly one transfer on the result channel with the popped
// word, a status code and the number of words held after the operation.
// A push to a full deque returns the full status and changes nothing; a pop
// from an empty deque returns zero with the empty status.
// For pushes and refused operations the result is registered at the
// accepting edge; a successful pop first reads the slot memory through
// its registered read port and loads the word in the read state, during
// which item_stall is high.
// The result register holds its contents while result_stall is high, and a
// new item is taken only in a cycle in which that register is free or is
// being drained, so the result register parts the two channels.
// Reset empties the deque and the result register; slot contents are not
// cleared, since only slots written by a push are ever read back.
// ============================================================================
module bounded_deque_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        mode,
    input  logic signed [bdq_pkg::WORD_W-1:0] value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [bdq_pkg::WORD_W-1:0] popped,
    output logic [1:0]                        status,
    output logic [bdq_pkg::OCC_W-1:0]         occupancy_out
);

    bdq_pkg::state_t               state_reg;
    bdq_pkg::state_t               state_next;
    bdq_pkg::op_t                  op;
    logic                          item_xfer;
    logic                          out_free;
    logic                          ram_we;
    logic                          ram_re;
    logic                          load_direct;
    logic                          load_read;
    logic [bdq_pkg::WORD_W-1:0]    ram_rdata;
    logic                          valid_reg;
    logic                          valid_next;
    logic [bdq_pkg::WORD_W-1:0]    popped_reg;
    bdq_pkg::status_t              status_reg;
    logic [bdq_pkg::OCC_W-1:0]     occ_out_reg;

    assign out_free  = !valid_reg || !result_stall;
    assign item_xfer = item_valid && !item_stall;

    bdq_ptr u_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (item_xfer),
        .mode  (mode),
        .op    (op)
    );

    bdq_ram #(
        .WIDTH (bdq_pkg::WORD_W),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op.slot),
        .wdata (value),
        .re    (ram_re),
        .raddr (op.slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (item_xfer && op.rd)
                begin
                    state_next = bdq_pkg::ST_READ;
                end
            end
            bdq_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = bdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall  = 1'b1;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load_direct = 1'b0;
        load_read   = 1'b0;
        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                item_stall  = !out_free;
                ram_we      = item_xfer && op.wr;
                ram_re      = item_xfer && op.rd;
                load_direct = item_xfer;
            end
            bdq_pkg::ST_READ:
            begin
                load_read = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load_read)
        begin
            valid_next = 1'b1;
        end
        else if (load_direct)
        begin
            valid_next = !op.rd;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            popped_reg  <= '0;
            status_reg  <= op.status;
            occ_out_reg <= op.occ_after;
        end
        else if (load_read)
        begin
            popped_reg <= ram_rdata;
        end
    end

    assign result_valid  = valid_reg;
    assign popped        = popped_reg;
    assign status        = status_reg;
    assign occupancy_out = occ_out_reg;

endmodule

/* hdl/bdq_checker.sv */
// ============================================================================
// bdq_checker
// Port-level checks on the result channel of the bounded deque engine.
// ============================================================================
module bdq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic signed [bdq_pkg::WORD_W-1:0] popped,
    input  logic [1:0]                        status,
    input  logic [bdq_pkg::OCC_W-1:0]         occupancy_out
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(popped) && $stable(status) && $stable(occupancy_out))
        else $error("Stalled result changed.");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != bdq_pkg::STATUS_DONE) |-> (popped == '0))
        else $error("Refused operation returned a nonzero word.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == bdq_pkg::STATUS_FULL) |->
            (occupancy_out == bdq_pkg::OCC_W'(bdq_pkg::DEPTH)))
        else $error("Full status without a full deque.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == bdq_pkg::STATUS_EMPTY) |-> (occupancy_out == '0))
        else $error("Empty status without an empty deque.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (occupancy_out <= bdq_pkg::OCC_W'(bdq_pkg::DEPTH)))
        else $error("Occupancy beyond the depth.");

endmodule

bind bounded_deque_engine bdq_checker u_bdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .popped        (popped),
    .status        (status),
    .occupancy_out (occupancy_out)
);
